### rtl/core/grid_vertex_normal_engine_defines.svh
// assertion macros for the grid vertex normal engine
`ifndef GRID_VERTEX_NORMAL_ENGINE_DEFINES_SVH
`define GRID_VERTEX_NORMAL_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define GVN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GVN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GVN_ASSERT(label, prop, msg)
`define GVN_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/core/gvn_pkg.sv
package gvn_pkg;

    localparam int DIM_W = 9;

    typedef logic signed [15:0] pos_t;
    typedef logic signed [15:0] q14_t;
    typedef logic signed [31:0] vec_t;

    typedef struct packed {
        logic start;
        logic edge_mode;
    } norm_req_t;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [15:0] ONE_Q14 = 16'd16384;

endpackage

### rtl/core/gvn_norm.sv
module gvn_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  gvn_pkg::norm_req_t req,
    input  gvn_pkg::vec_t     vec_in [3],
    output logic              done,
    output gvn_pkg::q14_t     norm_out [3]
);
    import gvn_pkg::*;

    localparam logic [1:0] N_IDLE = 2'd0;
    localparam logic [1:0] N_SQ   = 2'd1;
    localparam logic [1:0] N_SQRT = 2'd2;
    localparam logic [1:0] N_DIV  = 2'd3;

    logic [1:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic [29:0] mag_reg [3];
    logic [2:0]  neg_reg;
    logic        edge_reg;
    logic [59:0] prod_reg;
    logic [61:0] l2_reg;
    logic [63:0] rad_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [47:0] rem_reg;
    logic [47:0] dsr_reg;
    logic [15:0] q_reg;
    q14_t        out_reg [3];
    logic        done_reg;

    logic [29:0] mag_sel;
    logic [59:0] sq_w;
    logic [61:0] l2_sum;
    logic [63:0] sq_trial;
    logic        div_bit;
    logic [15:0] q_fin;
    logic [15:0] q_clamp;
    logic [31:0] abs_w [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_w[i] = vec_in[i][31] ? 32'(-vec_in[i]) : 32'(vec_in[i]);
        end
        mag_sel  = (cnt_reg[1:0] == 2'd3) ? 30'd0 : mag_reg[cnt_reg[1:0]];
        sq_w     = mag_sel * mag_sel;
        l2_sum   = l2_reg + {2'b0, prod_reg};
        sq_trial = res_reg + bit_reg;
        div_bit  = (rem_reg >= dsr_reg);
        q_fin    = {q_reg[14:0], div_bit};
        q_clamp  = (q_fin > ONE_Q14) ? ONE_Q14 : q_fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                N_IDLE:
                begin
                    if (req.start)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= abs_w[i][29:0];
                            neg_reg[i] <= vec_in[i][31];
                        end
                        edge_reg  <= req.edge_mode;
                        l2_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    prod_reg <= sq_w;
                    if (cnt_reg != 5'd0)
                    begin
                        l2_reg <= l2_sum;
                    end
                    if (cnt_reg == 5'd3)
                    begin
                        cnt_reg <= '0;
                        if (l2_sum == '0)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                out_reg[i] <= '0;
                            end
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            rad_reg   <= edge_reg ? {l2_sum[35:0], 28'b0} : {2'b0, l2_sum};
                            res_reg   <= '0;
                            bit_reg   <= 64'd1 << 62;
                            state_reg <= N_SQRT;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_SQRT:
                begin
                    if (rad_reg >= sq_trial)
                    begin
                        rad_reg <= rad_reg - sq_trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == 5'd31)
                    begin
                        cnt_reg   <= '0;
                        comp_reg  <= '0;
                        state_reg <= N_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_DIV:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        rem_reg <= (edge_reg ? (48'(mag_reg[comp_reg]) << 28)
                                             : (48'(mag_reg[comp_reg]) << 14))
                                   + 48'(res_reg[31:1]);
                        dsr_reg <= 48'(res_reg[31:0]) << 15;
                        q_reg   <= '0;
                        cnt_reg <= 5'd1;
                    end
                    else
                    begin
                        if (div_bit)
                        begin
                            rem_reg <= rem_reg - dsr_reg;
                        end
                        dsr_reg <= dsr_reg >> 1;
                        q_reg   <= q_fin;
                        if (cnt_reg == 5'd16)
                        begin
                            out_reg[comp_reg] <= neg_reg[comp_reg] ? q14_t'(-q_clamp)
                                                                   : q14_t'(q_clamp);
                            cnt_reg <= '0;
                            if (comp_reg == 2'd2)
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= N_IDLE;
                            end
                            else
                            begin
                                comp_reg <= comp_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 5'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign norm_out = out_reg;

endmodule

### rtl/core/grid_vertex_normal_engine.sv
// channel   signals                                             handshake
// request   req_type vertex_row vertex_col pos_x pos_y pos_z    start high, busy low
// result    normal_x normal_y normal_z tri_count                done pulse, one cycle
// config    cfg_index cfg_wdata                                 cfg_we high
//
// a write request leaves busy low
// a query outside the grid in use answers in the cycle after the request
// a query normalizes both edges and the cross product of each adjacent triangle,
// one at a time, in the shared square-root and divider unit in gvn_norm
// reset clears control state only; the position memory is undefined until written
// results cannot be stalled: done is high for exactly one cycle
`include "grid_vertex_normal_engine_defines.svh"

module grid_vertex_normal_engine #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [6:0]         vertex_row,
    input  logic [6:0]         vertex_col,
    input  gvn_pkg::pos_t      pos_x,
    input  gvn_pkg::pos_t      pos_y,
    input  gvn_pkg::pos_t      pos_z,
    output logic               done,
    output gvn_pkg::q14_t      normal_x,
    output gvn_pkg::q14_t      normal_y,
    output gvn_pkg::q14_t      normal_z,
    output logic [2:0]         tri_count,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_wdata
);
    import gvn_pkg::*;

    localparam int STRIDE = MAX_COLS + 1;
    localparam int DEPTH  = (MAX_ROWS + 1) * (MAX_COLS + 1);
    localparam int AW     = $clog2(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDV   = 4'd1;
    localparam logic [3:0] S_CAPV  = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_CAPB  = 4'd5;
    localparam logic [3:0] S_N1    = 4'd6;
    localparam logic [3:0] S_N2    = 4'd7;
    localparam logic [3:0] S_CROSS = 4'd8;
    localparam logic [3:0] S_NC    = 4'd9;
    localparam logic [3:0] S_AVG   = 4'd10;

    localparam logic [2:0] NB_UP    = 3'd0;
    localparam logic [2:0] NB_UL    = 3'd1;
    localparam logic [2:0] NB_LEFT  = 3'd2;
    localparam logic [2:0] NB_RIGHT = 3'd3;
    localparam logic [2:0] NB_DOWN  = 3'd4;
    localparam logic [2:0] NB_DR    = 3'd5;

    function automatic logic [2:0] first_tri(input logic [5:0] m);
        logic [2:0] f;
        f = 3'd0;
        for (int i = 5; i >= 0; i--)
        begin
            if (m[i])
            begin
                f = 3'(i);
            end
        end
        return f;
    endfunction

    logic [47:0]       mem [DEPTH];
    logic [47:0]       rd_data_reg;

    logic [6:0]        grid_rows_reg;
    logic [6:0]        grid_cols_reg;
    logic [3:0]        state_reg;
    logic [AW-1:0]     av_reg;
    logic [5:0]        mask_reg;
    logic [2:0]        tri_reg;
    logic [2:0]        count_reg;
    logic [2:0]        cnt_reg;
    logic [3:0]        step_reg;
    logic [1:0]        comp_reg;
    pos_t              v_reg [3];
    vec_t              e1_reg [3];
    vec_t              e2_reg [3];
    q14_t              n1_reg [3];
    q14_t              n2_reg [3];
    vec_t              c_reg [3];
    logic signed [31:0] prod_reg;
    logic signed [18:0] acc_reg [3];
    logic [17:0]       rem_reg;
    logic [17:0]       dsr_reg;
    logic [14:0]       q_reg;
    q14_t              out_reg [3];
    logic [2:0]        tri_count_reg;
    logic              done_reg;
    logic              norm_go_reg;
    logic              norm_edge_reg;

    logic              accept;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     nb_addr;
    logic [2:0]        nb_sel;
    logic [DIM_W-1:0]  rows_eff;
    logic [DIM_W-1:0]  cols_eff;
    logic [DIM_W-1:0]  row_w;
    logic [DIM_W-1:0]  col_w;
    logic              in_grid;
    logic [5:0]        mask_w;
    logic [5:0]        mask_left;
    logic [1:0]        a_idx;
    logic [1:0]        b_idx;
    logic [1:0]        c_idx;
    logic [17:0]       avg_mag;
    logic              avg_bit;
    logic [14:0]       avg_q;
    pos_t              rd_pos [3];
    vec_t              nvec [3];
    norm_req_t         norm_req;
    logic              norm_done;
    q14_t              norm_out [3];

    gvn_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (norm_req),
        .vec_in   (nvec),
        .done     (norm_done),
        .norm_out (norm_out)
    );

    assign norm_req.start     = norm_go_reg;
    assign norm_req.edge_mode = norm_edge_reg;

    always_comb
    begin
        accept   = start && !busy;
        row_w    = DIM_W'(vertex_row);
        col_w    = DIM_W'(vertex_col);
        rows_eff = (grid_rows_reg == 7'd0) ? DIM_W'(1) :
                   ((DIM_W'(grid_rows_reg) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                               : DIM_W'(grid_rows_reg));
        cols_eff = (grid_cols_reg == 7'd0) ? DIM_W'(1) :
                   ((DIM_W'(grid_cols_reg) > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS)
                                                               : DIM_W'(grid_cols_reg));
        in_grid  = (row_w <= rows_eff) && (col_w <= cols_eff);
        mask_w[0] = (row_w != '0) && (col_w != '0);
        mask_w[1] = mask_w[0];
        mask_w[2] = (row_w != '0) && (col_w < cols_eff);
        mask_w[3] = (row_w < rows_eff) && (col_w != '0);
        mask_w[4] = (row_w < rows_eff) && (col_w < cols_eff);
        mask_w[5] = mask_w[4];
        mask_left = mask_reg & ~(6'b1 << tri_reg);
        wr_addr  = AW'(32'(vertex_row) * STRIDE + 32'(vertex_col));
        mem_we   = accept && (req_type == REQ_WRITE) && (row_w <= DIM_W'(MAX_ROWS))
                   && (col_w <= DIM_W'(MAX_COLS));

        case (tri_reg)
            3'd0:    nb_sel = (state_reg == S_RDA) ? NB_UP    : NB_UL;
            3'd1:    nb_sel = (state_reg == S_RDA) ? NB_UL    : NB_LEFT;
            3'd2:    nb_sel = (state_reg == S_RDA) ? NB_RIGHT : NB_UP;
            3'd3:    nb_sel = (state_reg == S_RDA) ? NB_LEFT  : NB_DOWN;
            3'd4:    nb_sel = (state_reg == S_RDA) ? NB_DOWN  : NB_DR;
            default: nb_sel = (state_reg == S_RDA) ? NB_DR    : NB_RIGHT;
        endcase
        case (nb_sel)
            NB_UP:    nb_addr = av_reg - AW'(STRIDE);
            NB_UL:    nb_addr = av_reg - AW'(STRIDE + 1);
            NB_LEFT:  nb_addr = av_reg - AW'(1);
            NB_RIGHT: nb_addr = av_reg + AW'(1);
            NB_DOWN:  nb_addr = av_reg + AW'(STRIDE);
            default:  nb_addr = av_reg + AW'(STRIDE + 1);
        endcase
        rd_addr = (state_reg == S_RDV) ? av_reg : nb_addr;

        rd_pos[0] = rd_data_reg[47:32];
        rd_pos[1] = rd_data_reg[31:16];
        rd_pos[2] = rd_data_reg[15:0];

        case (state_reg)
            S_N1:    nvec = e1_reg;
            S_N2:    nvec = e2_reg;
            default: nvec = c_reg;
        endcase

        case (cnt_reg)
            3'd0:    begin a_idx = 2'd1; b_idx = 2'd2; end
            3'd1:    begin a_idx = 2'd2; b_idx = 2'd1; end
            3'd2:    begin a_idx = 2'd2; b_idx = 2'd0; end
            3'd3:    begin a_idx = 2'd0; b_idx = 2'd2; end
            3'd4:    begin a_idx = 2'd0; b_idx = 2'd1; end
            default: begin a_idx = 2'd1; b_idx = 2'd0; end
        endcase
        c_idx = 2'((cnt_reg - 3'd1) >> 1);

        avg_mag = acc_reg[comp_reg][18] ? 18'(-acc_reg[comp_reg]) : 18'(acc_reg[comp_reg]);
        avg_bit = (rem_reg >= dsr_reg);
        avg_q   = {q_reg[13:0], avg_bit};
    end

    // position memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {pos_x, pos_y, pos_z};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= 7'd64;
            grid_cols_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_GRID_ROWS)
            begin
                grid_rows_reg <= cfg_wdata;
            end
            else
            begin
                grid_cols_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            norm_go_reg   <= 1'b0;
            norm_edge_reg <= 1'b0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            comp_reg      <= '0;
            mask_reg      <= '0;
            tri_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            done_reg    <= 1'b0;
            norm_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (req_type == REQ_QUERY))
                    begin
                        if (!in_grid)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                out_reg[i] <= '0;
                            end
                            tri_count_reg <= '0;
                            done_reg      <= 1'b1;
                        end
                        else
                        begin
                            av_reg    <= wr_addr;
                            mask_reg  <= mask_w;
                            tri_reg   <= first_tri(mask_w);
                            count_reg <= 3'($countones(mask_w));
                            for (int i = 0; i < 3; i++)
                            begin
                                acc_reg[i] <= '0;
                            end
                            state_reg <= S_RDV;
                        end
                    end
                end
                S_RDV:
                begin
                    state_reg <= S_CAPV;
                end
                S_CAPV:
                begin
                    v_reg     <= rd_pos;
                    state_reg <= S_RDA;
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_reg[i] <= 32'(rd_pos[i]) - 32'(v_reg[i]);
                    end
                    state_reg <= S_CAPB;
                end
                S_CAPB:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e2_reg[i] <= 32'(rd_pos[i]) - 32'(v_reg[i]);
                    end
                    norm_go_reg   <= 1'b1;
                    norm_edge_reg <= 1'b1;
                    state_reg     <= S_N1;
                end
                S_N1:
                begin
                    if (norm_done)
                    begin
                        n1_reg        <= norm_out;
                        norm_go_reg   <= 1'b1;
                        norm_edge_reg <= 1'b1;
                        state_reg     <= S_N2;
                    end
                end
                S_N2:
                begin
                    if (norm_done)
                    begin
                        n2_reg  <= norm_out;
                        cnt_reg <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            c_reg[i] <= '0;
                        end
                        state_reg <= S_CROSS;
                    end
                end
                S_CROSS:
                begin
                    prod_reg <= n1_reg[a_idx] * n2_reg[b_idx];
                    if (cnt_reg != 3'd0)
                    begin
                        if (cnt_reg[0])
                        begin
                            c_reg[c_idx] <= c_reg[c_idx] + prod_reg;
                        end
                        else
                        begin
                            c_reg[c_idx] <= c_reg[c_idx] - prod_reg;
                        end
                    end
                    if (cnt_reg == 3'd6)
                    begin
                        norm_go_reg   <= 1'b1;
                        norm_edge_reg <= 1'b0;
                        state_reg     <= S_NC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
                S_NC:
                begin
                    if (norm_done)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            acc_reg[i] <= acc_reg[i] + 19'(norm_out[i]);
                        end
                        mask_reg <= mask_left;
                        tri_reg  <= first_tri(mask_left);
                        if (mask_left != '0)
                        begin
                            state_reg <= S_RDA;
                        end
                        else
                        begin
                            comp_reg  <= '0;
                            step_reg  <= '0;
                            state_reg <= S_AVG;
                        end
                    end
                end
                S_AVG:
                begin
                    if (step_reg == 4'd0)
                    begin
                        rem_reg  <= avg_mag + 18'(count_reg >> 1);
                        dsr_reg  <= 18'(count_reg) << 14;
                        q_reg    <= '0;
                        step_reg <= 4'd1;
                    end
                    else
                    begin
                        if (avg_bit)
                        begin
                            rem_reg <= rem_reg - dsr_reg;
                        end
                        dsr_reg <= dsr_reg >> 1;
                        q_reg   <= avg_q;
                        if (step_reg == 4'd15)
                        begin
                            // negated average
                            out_reg[comp_reg] <= acc_reg[comp_reg][18]
                                                 ? q14_t'(16'(avg_q))
                                                 : q14_t'(-16'(avg_q));
                            step_reg <= '0;
                            if (comp_reg == 2'd2)
                            begin
                                tri_count_reg <= count_reg;
                                done_reg      <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else
                            begin
                                comp_reg <= comp_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign normal_x  = out_reg[0];
    assign normal_y  = out_reg[1];
    assign normal_z  = out_reg[2];
    assign tri_count = tri_count_reg;

    `GVN_ASSERT(a_done_idle, done |-> !busy, "result shown while query still running")
    `GVN_ASSERT(a_busy_on_start, $rose(busy) |-> $past(start), "busy rose without a request")
    `GVN_ASSERT(a_count_range, done |-> (tri_count <= 3'd6), "triangle count out of range")
    `GVN_ASSERT_NEXT(a_write_idle, start && !busy && req_type == REQ_WRITE, !busy && !done,
        "write request started a query")

endmodule
